// ===== src/timed_priority_event_scheduler_macros.svh =====
// assertion macros for the timed priority event scheduler
`ifndef TIMED_PRIORITY_EVENT_SCHEDULER_MACROS_SVH
`define TIMED_PRIORITY_EVENT_SCHEDULER_MACROS_SVH
`ifndef SYNTH
`define TPES_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define TPES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define TPES_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TPES_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/tpes_pkg.sv =====
// package: types and constants of the timed priority event scheduler
`timescale 1ns / 1ps
package tpes_pkg;
   localparam int READY_DEPTH = 16;
   localparam int WAIT_DEPTH  = 16;
   localparam int TIME_BITS   = 32;
   localparam int TAG_BITS    = 8;
   localparam int PRIO_BITS   = 8;
   localparam int RIDX_BITS   = $clog2(READY_DEPTH);
   localparam int WIDX_BITS   = $clog2(WAIT_DEPTH);
   localparam int RCNT_BITS   = $clog2(READY_DEPTH + 1);
   localparam int WCNT_BITS   = $clog2(WAIT_DEPTH + 1);

   localparam logic [1:0] MODE_NOW   = 2'd0;
   localparam logic [1:0] MODE_TIMED = 2'd1;
   localparam logic [1:0] MODE_DISP  = 2'd2;
   localparam logic [1:0] MODE_STOP  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_EMPTY   = 2'd2;
   localparam logic [1:0] ST_STOPPED = 2'd3;

   typedef struct packed {
      logic [1:0]           mode;
      logic [TIME_BITS-1:0] now_time;
      logic [TIME_BITS-1:0] due_time;
      logic [PRIO_BITS-1:0] priority_req;
      logic [TAG_BITS-1:0]  event_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic                 dispatched;
      logic [TAG_BITS-1:0]  out_tag;
      logic [4:0]           ready_count;
      logic [4:0]           waiting_count;
      logic                 wake_valid;
      logic [TIME_BITS-1:0] wake_time;
   } rsp_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] time_val;
      logic [PRIO_BITS-1:0] prio;
      logic [TAG_BITS-1:0]  tag;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture request
      logic ins_ready;   // insert held entry into ready store
      logic ins_wait;    // insert held entry into waiting store
      logic move_one;    // move waiting head into ready store
      logic pop;         // pop ready head to result
      logic set_stop;
      logic [1:0] status;
      logic finish;      // build result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] mode;
      logic       stopped;
      logic       ready_full;
      logic       ready_empty;
      logic       wait_full;
      logic       head_due;  // waiting head expired
   } stat_type;
endpackage

// ===== src/tpes_datapath.sv =====
// datapath: sorted ready and waiting stores held as shift registers
`timescale 1ns / 1ps
module tpes_datapath (
   input  logic              clock,
   input  logic              reset,
   input  tpes_pkg::req_type req,
   input  tpes_pkg::cmd_type cmd,
   output tpes_pkg::stat_type stat,
   output tpes_pkg::rsp_type rsp_data
);
   localparam int RD = tpes_pkg::READY_DEPTH;
   localparam int WD = tpes_pkg::WAIT_DEPTH;

   tpes_pkg::req_type   req_ff;
   tpes_pkg::entry_type rdy_ff [RD];
   tpes_pkg::entry_type rdy_in [RD];
   tpes_pkg::entry_type wt_ff [WD];
   tpes_pkg::entry_type wt_in [WD];
   logic [tpes_pkg::RCNT_BITS-1:0] rfill_ff, rfill_in;
   logic [tpes_pkg::WCNT_BITS-1:0] wfill_ff, wfill_in;
   logic stop_ff, stop_in;
   logic disp_ff, disp_in;
   logic [tpes_pkg::TAG_BITS-1:0] otag_ff, otag_in;
   tpes_pkg::rsp_type rsp_ff, rsp_in;

   tpes_pkg::entry_type new_e, rins_e;
   logic rins;
   logic [RD-1:0] r_after;
   logic [WD-1:0] w_after;

   always_comb begin
      new_e.prio = req_ff.priority_req;
      new_e.tag  = req_ff.event_tag;
      new_e.time_val = (req_ff.mode == tpes_pkg::MODE_TIMED) ? req_ff.due_time
                                                             : req_ff.now_time;
      rins   = cmd.ins_ready | cmd.move_one;
      rins_e = cmd.move_one ? wt_ff[0] : new_e;
   end

   // per slot: slot is occupied and must be served strictly after the new entry
   always_comb begin
      for (int i = 0; i < RD; i++) begin
         r_after[i] = (RD'(i) < RD'(rfill_ff)) &&
            ((rdy_ff[i].prio != rins_e.prio) ? (rdy_ff[i].prio > rins_e.prio)
                                              : (rdy_ff[i].time_val > rins_e.time_val));
      end
      for (int i = 0; i < WD; i++) begin
         w_after[i] = (WD'(i) < WD'(wfill_ff)) && (wt_ff[i].time_val > new_e.time_val);
      end
   end

   always_comb begin
      rdy_in   = rdy_ff;
      wt_in    = wt_ff;
      rfill_in = rfill_ff;
      wfill_in = wfill_ff;
      stop_in  = stop_ff | cmd.set_stop;
      disp_in  = disp_ff;
      otag_in  = otag_ff;
      if (cmd.load) begin
         disp_in = 1'b0;
         otag_in = '0;
      end
      if (rins) begin
         for (int i = 0; i < RD; i++) begin
            if (r_after[i]) begin
               if (i > 0) begin
                  rdy_in[i] = rdy_ff[i-1];
               end
               if (i == 0 || !r_after[i-1]) begin
                  rdy_in[i] = rins_e;
               end
            end else if (RD'(i) == RD'(rfill_ff)) begin
               if (i == 0 || !r_after[i-1]) begin
                  rdy_in[i] = rins_e;
               end else begin
                  rdy_in[i] = rdy_ff[i-1];
               end
            end
         end
         rfill_in = rfill_ff + 1'b1;
      end
      if (cmd.ins_wait) begin
         for (int i = 0; i < WD; i++) begin
            if (w_after[i]) begin
               if (i > 0) begin
                  wt_in[i] = wt_ff[i-1];
               end
               if (i == 0 || !w_after[i-1]) begin
                  wt_in[i] = new_e;
               end
            end else if (WD'(i) == WD'(wfill_ff)) begin
               if (i == 0 || !w_after[i-1]) begin
                  wt_in[i] = new_e;
               end else begin
                  wt_in[i] = wt_ff[i-1];
               end
            end
         end
         wfill_in = wfill_ff + 1'b1;
      end
      if (cmd.move_one) begin
         for (int i = 0; i < WD - 1; i++) begin
            wt_in[i] = wt_ff[i+1];
         end
         wfill_in = wfill_ff - 1'b1;
      end
      if (cmd.pop) begin
         for (int i = 0; i < RD - 1; i++) begin
            rdy_in[i] = rdy_ff[i+1];
         end
         rfill_in = rfill_ff - 1'b1;
         disp_in  = 1'b1;
         otag_in  = rdy_ff[0].tag;
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.finish) begin
         rsp_in.status        = cmd.status;
         rsp_in.dispatched    = disp_ff;
         rsp_in.out_tag       = otag_ff;
         rsp_in.ready_count   = 5'(rfill_ff);
         rsp_in.waiting_count = 5'(wfill_ff);
         rsp_in.wake_valid    = (wfill_ff != '0);
         rsp_in.wake_time     = (wfill_ff != '0) ? wt_ff[0].time_val : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req;
      end
      rdy_ff <= rdy_in;
      wt_ff  <= wt_in;
      otag_ff <= otag_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         rfill_ff <= '0;
         wfill_ff <= '0;
         stop_ff  <= 1'b0;
         disp_ff  <= 1'b0;
      end else begin
         rfill_ff <= rfill_in;
         wfill_ff <= wfill_in;
         stop_ff  <= stop_in;
         disp_ff  <= disp_in;
      end
   end

   always_comb begin
      stat.mode        = req_ff.mode;
      stat.stopped     = stop_ff;
      stat.ready_full  = (rfill_ff == tpes_pkg::RCNT_BITS'(RD));
      stat.ready_empty = (rfill_ff == '0);
      stat.wait_full   = (wfill_ff == tpes_pkg::WCNT_BITS'(WD));
      stat.head_due    = (wfill_ff != '0) && (wt_ff[0].time_val <= req_ff.now_time);
   end

   assign rsp_data = rsp_ff;
endmodule

// ===== src/tpes_ctrl.sv =====
// controller: sequences one request through the datapath
`timescale 1ns / 1ps
`include "timed_priority_event_scheduler_macros.svh"
module tpes_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  tpes_pkg::stat_type stat,
   output tpes_pkg::cmd_type  cmd
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_MOVE = 3'd2;
   localparam logic [2:0] S_POP  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [1:0] status_ff, status_in;
   logic       vld_ff, vld_in;

   // the result may be written once the output slot is free or being drained
   logic slot_free;
   logic [3:0] op_vec;
   assign slot_free = !vld_ff || !rsp_stall;
   assign req_stall = !(state_ff == S_IDLE);
   assign op_vec = {cmd.ins_ready, cmd.ins_wait, cmd.move_one, cmd.pop};

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      vld_in    = vld_ff && rsp_stall;
      cmd       = '0;
      cmd.status = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = tpes_pkg::ST_OK;
            state_in  = S_DONE;
            unique case (stat.mode)
               tpes_pkg::MODE_NOW: begin
                  if (stat.ready_full) status_in = tpes_pkg::ST_FULL;
                  else cmd.ins_ready = 1'b1;
               end
               tpes_pkg::MODE_TIMED: begin
                  if (stat.wait_full) status_in = tpes_pkg::ST_FULL;
                  else cmd.ins_wait = 1'b1;
               end
               tpes_pkg::MODE_DISP: begin
                  if (stat.stopped) status_in = tpes_pkg::ST_STOPPED;
                  else state_in = S_MOVE;
               end
               default: begin
                  cmd.set_stop = 1'b1;
                  status_in = tpes_pkg::ST_STOPPED;
               end
            endcase
         end
         S_MOVE: begin
            if (stat.head_due && !stat.ready_full) begin
               cmd.move_one = 1'b1;
            end else begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            if (stat.ready_empty) begin
               status_in = tpes_pkg::ST_EMPTY;
            end else begin
               cmd.pop = 1'b1;
               status_in = tpes_pkg::ST_OK;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.finish = 1'b1;
               vld_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
   end

   assign rsp_valid = vld_ff;

   `TPES_ASSERT_IMPL(a_one_op, clock, reset, 1'b1, $onehot0(op_vec))
   `TPES_ASSERT_IMPL(a_no_move_stopped, clock, reset, cmd.move_one, !stat.stopped && !stat.ready_full)
   `TPES_ASSERT_NEXT(a_load_exec, clock, reset, cmd.load, state_ff == S_EXEC)
   `TPES_ASSERT_IMPL(a_finish_slot, clock, reset, cmd.finish, !vld_ff || !rsp_stall)
endmodule

// ===== src/timed_priority_event_scheduler.sv =====
// top level of the timed priority event scheduler
// schedule and stop: idle, execute and done states from transfer in to result valid
// dispatch: idle, execute, move (one waiting entry per cycle, up to 16), pop and done states
// a new request is taken only once the controller is back in idle, so requests never overlap
// reset: synchronous, clears fills, stop flag, state machine and output valid
`timescale 1ns / 1ps
module timed_priority_event_scheduler (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tpes_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tpes_pkg::rsp_type rsp_data
);
   tpes_pkg::cmd_type  cmd;
   tpes_pkg::stat_type stat;

   tpes_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .stat(stat), .cmd(cmd)
   );

   tpes_datapath u_dp (
      .clock(clock), .reset(reset),
      .req(req_data), .cmd(cmd), .stat(stat), .rsp_data(rsp_data)
   );
endmodule

// ===== bench/testbench.sv =====
// testbench for the timed priority event scheduler: directed table, random traffic, self-check
`timescale 1ns / 1ps
module testbench;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_ITEMS = 1600;

   typedef struct {
      tpes_pkg::req_type req;
      bit                known;   // expected result typed in below
      tpes_pkg::rsp_type want;
   } row_type;

   typedef struct {
      bit                known;
      tpes_pkg::rsp_type want;
   } pending_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   tpes_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   tpes_pkg::rsp_type rsp_data;

   timed_priority_event_scheduler uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // shadow copy of the scheduler state
   tpes_pkg::entry_type ready_q[tpes_pkg::READY_DEPTH + 1];
   tpes_pkg::entry_type sleep_q[tpes_pkg::WAIT_DEPTH + 1];
   int          ready_n;
   int          sleep_n;
   bit          frozen;

   tpes_pkg::rsp_type result_q[$];
   pending_type typed_q[$];
   row_type     rows[$];
   row_type     tail_rows[$];
   int          gap_pct;
   int          stall_pct;
   bit          long_hold;
   int          hold_left;
   int          errors;
   int          cycles;
   int          n_items;
   int          n_tags;
   int          n_drops;
   int          n_empty;
   int          n_results;

   function automatic bit ready_place(tpes_pkg::entry_type e);
      int p;
      if (ready_n >= tpes_pkg::READY_DEPTH) return 1'b0;
      p = 0;
      while (p < ready_n && !(ready_q[p].prio > e.prio ||
             (ready_q[p].prio == e.prio && ready_q[p].time_val > e.time_val)))
         p++;
      for (int i = ready_n; i > p; i--) ready_q[i] = ready_q[i-1];
      ready_q[p] = e;
      ready_n++;
      return 1'b1;
   endfunction

   function automatic bit sleep_place(tpes_pkg::entry_type e);
      int p;
      if (sleep_n >= tpes_pkg::WAIT_DEPTH) return 1'b0;
      p = 0;
      while (p < sleep_n && sleep_q[p].time_val <= e.time_val) p++;
      for (int i = sleep_n; i > p; i--) sleep_q[i] = sleep_q[i-1];
      sleep_q[p] = e;
      sleep_n++;
      return 1'b1;
   endfunction

   function automatic tpes_pkg::rsp_type schedule_step(tpes_pkg::req_type r);
      tpes_pkg::rsp_type   o;
      tpes_pkg::entry_type e;
      int                  moved;
      o = '0;
      e.prio = r.priority_req;
      e.tag = r.event_tag;
      e.time_val = r.now_time;
      case (r.mode)
         tpes_pkg::MODE_NOW: begin
            if (!ready_place(e)) o.status = tpes_pkg::ST_FULL;
         end
         tpes_pkg::MODE_TIMED: begin
            e.time_val = r.due_time;
            if (!sleep_place(e)) o.status = tpes_pkg::ST_FULL;
         end
         tpes_pkg::MODE_DISP: begin
            if (frozen) begin
               o.status = tpes_pkg::ST_STOPPED;
            end else begin
               moved = 0;
               // expired entries move in due order until the ready side is full
               while (moved < sleep_n && sleep_q[moved].time_val <= r.now_time) begin
                  if (!ready_place(sleep_q[moved])) break;
                  moved++;
               end
               for (int i = 0; i + moved < sleep_n; i++) sleep_q[i] = sleep_q[i+moved];
               sleep_n -= moved;
               if (ready_n == 0) begin
                  o.status = tpes_pkg::ST_EMPTY;
               end else begin
                  o.dispatched = 1'b1;
                  o.out_tag = ready_q[0].tag;
                  for (int i = 1; i < ready_n; i++) ready_q[i-1] = ready_q[i];
                  ready_n--;
               end
            end
         end
         default: begin
            frozen = 1'b1;
            o.status = tpes_pkg::ST_STOPPED;
         end
      endcase
      o.ready_count = 5'(ready_n);
      o.waiting_count = 5'(sleep_n);
      o.wake_valid = (sleep_n > 0);
      o.wake_time = (sleep_n > 0) ? sleep_q[0].time_val : '0;
      return o;
   endfunction

   function automatic tpes_pkg::req_type make_req(logic [1:0] m, logic [31:0] now_t,
                                                  logic [31:0] due_t,
                                                  logic [7:0] prio, logic [7:0] tag);
      tpes_pkg::req_type r;
      r.mode = m;
      r.now_time = now_t;
      r.due_time = due_t;
      r.priority_req = prio;
      r.event_tag = tag;
      return r;
   endfunction

   task automatic add_row(ref row_type q[$], input tpes_pkg::req_type r);
      row_type w;
      w.req = r;
      w.known = 1'b0;
      w.want = '0;
      q.push_back(w);
   endtask

   task automatic compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         errors++;
      end
   endtask

   // drive one item, waiting out random idle cycles and stalls
   task automatic send(input tpes_pkg::req_type r, input bit known,
                       input tpes_pkg::rsp_type want);
      pending_type p;
      p.known = known;
      p.want = want;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      typed_q.push_back(p);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_plain(input tpes_pkg::req_type r);
      send(r, 1'b0, '0);
   endtask

   // receiver: random stall, or a long hold-off when requested
   always @(negedge clock) begin
      if (long_hold) begin
         long_hold = 1'b0;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // transfer monitor and checker
   always @(posedge clock) begin
      pending_type       p;
      tpes_pkg::rsp_type w;
      tpes_pkg::rsp_type got;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            p = typed_q.pop_front();
            w = schedule_step(req_data);
            result_q.push_back(p.known ? p.want : w);
            n_items++;
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            n_results++;
            if (result_q.size() == 0) begin
               $error("result with no expectation waiting");
               errors++;
            end else begin
               w = result_q.pop_front();
               compare_field("status", w.status, got.status);
               compare_field("dispatched", w.dispatched, got.dispatched);
               compare_field("out_tag", w.out_tag, got.out_tag);
               compare_field("ready_count", w.ready_count, got.ready_count);
               compare_field("waiting_count", w.waiting_count, got.waiting_count);
               compare_field("wake_valid", w.wake_valid, got.wake_valid);
               compare_field("wake_time", w.wake_time, got.wake_time);
               if (got.dispatched) n_tags++;
               if (got.status == tpes_pkg::ST_FULL) n_drops++;
               if (got.status == tpes_pkg::ST_EMPTY) n_empty++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      row_type           w;
      tpes_pkg::req_type r;
      logic [31:0]       now_t;
      logic [1:0]        m;
      int                pick;
      int                insert_bias;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      long_hold = 1'b0;
      hold_left = 0;
      gap_pct = 35;
      stall_pct = 72;
      errors = 0;
      cycles = 0;
      n_items = 0;
      n_tags = 0;
      n_drops = 0;
      n_empty = 0;
      n_results = 0;
      ready_n = 0;
      sleep_n = 0;
      frozen = 1'b0;

      // dispatch right after reset: nothing anywhere
      w.req = make_req(tpes_pkg::MODE_DISP, '1, '1, '1, '1);
      w.known = 1'b1;
      w.want = '0;
      w.want.status = tpes_pkg::ST_EMPTY;
      rows.push_back(w);
      add_row(rows, make_req(tpes_pkg::MODE_NOW, '1, '0, 8'hff, 8'hff));
      add_row(rows, make_req(tpes_pkg::MODE_NOW, 32'd7, '1, 8'h00, 8'h00));
      add_row(rows, make_req(tpes_pkg::MODE_NOW, 32'd7, '0, 8'h00, 8'h01));   // tie, served second
      add_row(rows, make_req(tpes_pkg::MODE_NOW, 32'd3, '0, 8'h00, 8'h02));   // earlier time wins
      add_row(rows, make_req(tpes_pkg::MODE_TIMED, '0, '1, 8'h80, 8'h10));
      add_row(rows, make_req(tpes_pkg::MODE_TIMED, '0, 32'd0, 8'h01, 8'h11));
      // tie in waiting order
      add_row(rows, make_req(tpes_pkg::MODE_TIMED, '0, 32'd0, 8'h01, 8'h12));
      add_row(rows, make_req(tpes_pkg::MODE_TIMED, '0, 32'd50, 8'h00, 8'h13));
      add_row(rows, make_req(tpes_pkg::MODE_DISP, 32'd0, '1, 8'h55, 8'haa));
      add_row(rows, make_req(tpes_pkg::MODE_DISP, 32'd0, '0, 8'haa, 8'h55));
      add_row(rows, make_req(tpes_pkg::MODE_DISP, 32'd49, '0, '0, '0));
      add_row(rows, make_req(tpes_pkg::MODE_DISP, 32'd50, '0, '0, '0));
      add_row(rows, make_req(tpes_pkg::MODE_DISP, 32'd50, '0, '0, '0));
      add_row(rows, make_req(tpes_pkg::MODE_DISP, 32'd50, '0, '0, '0));
      add_row(rows, make_req(tpes_pkg::MODE_DISP, 32'd50, '0, '0, '0));
      add_row(rows, make_req(tpes_pkg::MODE_DISP, 32'd50, '0, '0, '0));  // empty, one still waits
      add_row(rows, make_req(tpes_pkg::MODE_DISP, '1, '0, '0, '0));       // far future drains it
      add_row(rows, make_req(tpes_pkg::MODE_DISP, '1, '0, '0, '0));
      // stop and what follows it, sent at the very end since stop sticks until reset
      add_row(tail_rows, make_req(tpes_pkg::MODE_TIMED, 32'd0, 32'd9, 8'h04, 8'h21));
      add_row(tail_rows, make_req(tpes_pkg::MODE_STOP, '1, '1, '1, '1));
      add_row(tail_rows, make_req(tpes_pkg::MODE_DISP, '1, '0, '0, '0));
      add_row(tail_rows, make_req(tpes_pkg::MODE_NOW, 32'd1, '0, 8'h02, 8'h22));
      add_row(tail_rows, make_req(tpes_pkg::MODE_STOP, '0, '0, '0, '0));
      add_row(tail_rows, make_req(tpes_pkg::MODE_DISP, '0, '0, '0, '0));

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (rows[i]) send(rows[i].req, rows[i].known, rows[i].want);

      now_t = $urandom;
      insert_bias = 85;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 3) begin
            gap_pct = 72;
            stall_pct = 35;
         end
         if (i == 2 * RANDOM_ITEMS / 3) begin
            gap_pct = 0;
            stall_pct = 0;
            long_hold = 1'b1;
         end
         // alternate stretches that fill the stores and ones that drain them
         if (i % 80 == 0) insert_bias = (insert_bias == 85) ? 30 : 85;
         now_t += $urandom_range(3);
         pick = $urandom_range(99);
         if (pick < insert_bias) begin
            m = ($urandom_range(1) == 0) ? tpes_pkg::MODE_NOW : tpes_pkg::MODE_TIMED;
         end else begin
            m = tpes_pkg::MODE_DISP;
         end
         r = make_req(m, now_t, now_t + $urandom_range(20), 8'($urandom_range(3)),
                      8'($urandom));
         if ($urandom_range(19) == 0) begin
            r.now_time = $urandom;
            r.due_time = $urandom;
            r.priority_req = 8'($urandom);
         end
         send_plain(r);
      end

      foreach (tail_rows[i]) send(tail_rows[i].req, tail_rows[i].known, tail_rows[i].want);
      req_valid <= 1'b0;

      while (result_q.size() > 0 || typed_q.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("%0d requests, %0d results: %0d tags dispatched, %0d inserts dropped full,",
               n_items, n_results, n_tags, n_drops);
      $display("%0d empty dispatches, stop exercised at the end, three idle/stall profiles",
               n_empty);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
